>>> hw/rtl/fdrf_pkg.sv
// ----------------------------------------------------------------------------
// fdrf_pkg
// Shared constants, types and helpers of the frame dirty rectangle finder.
// ----------------------------------------------------------------------------
package fdrf_pkg;

    localparam int unsigned MAX_ROW_WORDS = 4096;
    localparam int unsigned MAX_ROWS      = 4096;

    // word width
    localparam int unsigned WORD_W = 32;
    // position counters hold 0 .. MAX - 1
    localparam int unsigned CNT_W  = $clog2(MAX_ROW_WORDS > MAX_ROWS ? MAX_ROW_WORDS : MAX_ROWS);
    // sizes hold 0 .. MAX
    localparam int unsigned SIZE_W = CNT_W + 1;
    // column edges in pixels, after the pixel shift
    localparam int unsigned EDGE_W = SIZE_W + 1;

    localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_ROW_WORDS);
    localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_ROWS);

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_WORDS   = 2'd0,
        CFG_FRAME_ROWS  = 2'd1,
        CFG_PIXEL_SHIFT = 2'd2
    } cfg_index_t;

    localparam logic [SIZE_W-1:0] ROW_WORDS_RESET  = SIZE_W'(1024);
    localparam logic [SIZE_W-1:0] FRAME_ROWS_RESET = SIZE_W'(768);

    // tracker status for the word currently presented
    typedef struct packed {
        logic frame_end;   // this word closes the frame
        logic emit;        // closing a frame that had a change
    } trk_status_t;

    // rectangle in pixels (columns) and rows
    typedef struct packed {
        logic [EDGE_W-1:0] left;
        logic [SIZE_W-1:0] top;
        logic [EDGE_W-1:0] right;
        logic [SIZE_W-1:0] bottom;
    } rect_t;

    // zero taken as one, oversize taken as the maximum
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/frame_dirty_rect_finder_unit.sv
// ----------------------------------------------------------------------------
// frame_dirty_rect_finder_unit
// Bounding box of the changed words of a frame, streamed as word pairs.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   s_valid/s_ready    s_reference_word, s_current_word
//  m_*       out  m_valid/m_ready    m_dirty_left/top/right/bottom
//  cfg_*     in   cfg_wr_en          cfg_index, cfg_data
//
//  one beat per cycle sustained, save for the stall below; an accepted beat
//  passes the input register, then the tracker, into the result register
//  only the frame's last beat can produce a result, and only if a change was seen
//  a stalled result blocks the input stage only when the next beat also
//  closes a changed frame; all other beats keep flowing
//  synchronous active-low reset restores register defaults and a fresh frame
//
module frame_dirty_rect_finder_unit
    import fdrf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input beats
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_reference_word,
    input  logic [WORD_W-1:0]    s_current_word,
    // result beats
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [EDGE_W-1:0]    m_dirty_left,
    output logic [SIZE_W-1:0]    m_dirty_top,
    output logic [EDGE_W-1:0]    m_dirty_right,
    output logic [SIZE_W-1:0]    m_dirty_bottom,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data
);

    // configuration registers
    logic [SIZE_W-1:0] row_words_reg;
    logic [SIZE_W-1:0] frame_rows_reg;
    logic              pixel_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_words_reg   <= ROW_WORDS_RESET;
            frame_rows_reg  <= FRAME_ROWS_RESET;
            pixel_shift_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ROW_WORDS:   row_words_reg   <= cfg_data;
                CFG_FRAME_ROWS:  frame_rows_reg  <= cfg_data;
                CFG_PIXEL_SHIFT: pixel_shift_reg <= cfg_data[0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // input register stage
    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_ref_reg;
    logic [WORD_W-1:0] s1_cur_reg;
    logic              s1_advance;
    logic              out_free;
    trk_status_t       trk_status;
    rect_t             trk_rect;

    // result slot is free if empty or being drained this cycle
    assign out_free   = !m_valid || m_ready;
    // beats with no result never wait on the output side
    assign s1_advance = s1_valid_reg && (!trk_status.emit || out_free);
    assign s_ready    = !s1_valid_reg || s1_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_ref_reg <= s_reference_word;
            s1_cur_reg <= s_current_word;
        end
    end

    // position counters and bounding box
    fdrf_frame_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (s1_advance),
        .diff        (s1_ref_reg != s1_cur_reg),
        .row_words   (row_words_reg),
        .frame_rows  (frame_rows_reg),
        .pixel_shift (pixel_shift_reg),
        .status      (trk_status),
        .rect        (trk_rect)
    );

    // result register
    logic  m_valid_reg;
    rect_t m_rect_reg;
    logic  load_out;

    assign load_out = s1_advance && trk_status.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_rect_reg <= trk_rect;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_dirty_left   = m_rect_reg.left;
    assign m_dirty_top    = m_rect_reg.top;
    assign m_dirty_right  = m_rect_reg.right;
    assign m_dirty_bottom = m_rect_reg.bottom;

    // a held input beat keeps its words until the tracker takes it
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_ref_reg) &&
                                        $stable(s1_cur_reg))
        else $error("input stage lost a held beat");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && m_valid_reg |-> m_ready)
        else $error("result register overwritten while stalled");

endmodule

>>> hw/rtl/fdrf_frame_tracker.sv
// ----------------------------------------------------------------------------
// fdrf_frame_tracker
// Raster position counters, bounding box of changed words and rectangle math.
// ----------------------------------------------------------------------------
module fdrf_frame_tracker
    import fdrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              diff,
    input  logic [SIZE_W-1:0] row_words,
    input  logic [SIZE_W-1:0] frame_rows,
    input  logic              pixel_shift,
    output trk_status_t       status,
    output rect_t             rect
);

    logic [CNT_W-1:0] col_reg, row_reg;
    logic [CNT_W-1:0] min_col_reg, max_col_reg, min_row_reg, max_row_reg;
    logic             any_reg;

    logic [CNT_W-1:0] min_col_next, max_col_next, min_row_next, max_row_next;
    logic             any_next;
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [SIZE_W-1:0] col_inc, row_inc;
    logic              row_end;
    logic [CNT_W-1:0]  left_w, top_w;
    logic [SIZE_W-1:0] right_w, bottom_w;

    assign w_eff = clamp_size(row_words, MAX_W_SIZE);
    assign h_eff = clamp_size(frame_rows, MAX_H_SIZE);

    // box including the word presented now
    always_comb begin
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        if (diff) begin
            if (!any_reg) begin
                min_col_next = col_reg;
                max_col_next = col_reg;
                min_row_next = row_reg;
                max_row_next = row_reg;
            end else begin
                if (col_reg < min_col_reg) min_col_next = col_reg;
                if (col_reg > max_col_reg) max_col_next = col_reg;
                if (row_reg < min_row_reg) min_row_next = row_reg;
                if (row_reg > max_row_reg) max_row_next = row_reg;
            end
        end
    end

    assign any_next = any_reg | diff;

    assign col_inc = {1'b0, col_reg} + SIZE_W'(1);
    assign row_inc = {1'b0, row_reg} + SIZE_W'(1);
    assign row_end = col_inc >= w_eff;

    assign status.frame_end = row_end && (row_inc >= h_eff);
    assign status.emit      = status.frame_end && any_next;

    // widen by one, clamp, then convert columns to pixels
    always_comb begin
        left_w   = (min_col_next == '0) ? '0 : min_col_next - CNT_W'(1);
        top_w    = (min_row_next == '0) ? '0 : min_row_next - CNT_W'(1);
        right_w  = {1'b0, max_col_next} + SIZE_W'(1);
        bottom_w = {1'b0, max_row_next} + SIZE_W'(1);
        if (right_w > w_eff) right_w = w_eff;
        if (bottom_w > h_eff) bottom_w = h_eff;
        rect.left   = {2'b00, left_w} << pixel_shift;
        rect.top    = {1'b0, top_w};
        rect.right  = {1'b0, right_w} << pixel_shift;
        rect.bottom = bottom_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_col_reg <= '0;
            max_col_reg <= '0;
            min_row_reg <= '0;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
        end else if (step) begin
            if (status.frame_end) begin
                col_reg     <= '0;
                row_reg     <= '0;
                min_col_reg <= '0;
                max_col_reg <= '0;
                min_row_reg <= '0;
                max_row_reg <= '0;
                any_reg     <= 1'b0;
            end else begin
                if (row_end) begin
                    col_reg <= '0;
                    row_reg <= row_reg + CNT_W'(1);
                end else begin
                    col_reg <= col_reg + CNT_W'(1);
                end
                min_col_reg <= min_col_next;
                max_col_reg <= max_col_next;
                min_row_reg <= min_row_next;
                max_row_reg <= max_row_next;
                any_reg     <= any_next;
            end
        end
    end

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && status.frame_end |=> col_reg == '0 && row_reg == '0 && !any_reg)
        else $error("tracker state not cleared after frame end");

    a_box_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        any_reg |-> min_col_reg <= max_col_reg && min_row_reg <= max_row_reg)
        else $error("bounding box edges out of order");

    a_idle_box_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !any_reg |-> min_col_reg == '0 && max_col_reg == '0 &&
                     min_row_reg == '0 && max_row_reg == '0)
        else $error("box holds data while no change seen");

endmodule
